// ===== rtl/sht128_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256/128 hasher package
// Field widths, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sht128_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned BlkBits = 512;
  localparam int unsigned CountW  = 62;
  localparam int unsigned FillW   = 6;
  localparam int unsigned RoundW  = 6;

  typedef logic [WordW-1:0] word_t;
  typedef logic [7:0][WordW-1:0] hash_t;

  localparam logic [ByteW-1:0] PadMark = 8'h80;
  localparam logic [FillW-1:0] FillLast = 6'd63;
  localparam logic [FillW-1:0] FillLen  = 6'd56;
  localparam logic [RoundW-1:0] RoundLast = 6'd63;

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam hash_t InitHash = '{
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sht128_in_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256/128 request channel
// Valid/ready channel carrying one message byte and its flags.
// ----------------------------------------------------------------------------
interface sht128_in_if;
  import sht128_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             has_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_byte,
                output ready);
endinterface

// ===== rtl/sht128_out_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256/128 result channel
// Valid/ready channel carrying the truncated digest and the length flag.
// ----------------------------------------------------------------------------
interface sht128_out_if;
  import sht128_pkg::*;

  logic             valid;
  logic             ready;
  logic [HalfW-1:0] digest_high;
  logic [HalfW-1:0] digest_low;
  logic             length_error;

  modport source (output valid, output digest_high, output digest_low,
                  output length_error, input ready);
  modport sink (input valid, input digest_high, input digest_low,
                input length_error, output ready);
endinterface

// ===== rtl/sha256_truncated_128_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher, digest truncated to 128 bits
// Flow: idle takes one byte per request; each 64th byte starts a compression
//   (64 rounds of the shared round unit, a chaining update) with requests held.
// Last request: the mark byte and zero bytes go in one at a time, the bit
//   length at once, with one or two compressions; the digest is registered in
//   the final chaining-update state, later while a previous result waits.
// Reset: chaining words load the initial hash, counts clear, no result pending.
// ----------------------------------------------------------------------------
module sha256_truncated_128_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  sht128_in_if.sink          req_i,
  sht128_out_if.source       rsp_o
);
  import sht128_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MARK = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [2:0]          ret_q, ret_d;
  logic                final_q, final_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [CountW-1:0]   count_q, count_d;
  hash_t               chain_q, chain_d;
  hash_t               work_q, work_d;
  logic [BlkBits-1:0]  blk_q, blk_d;
  logic                out_valid_q, out_valid_d;
  logic [HalfW-1:0]    dig_hi_q, dig_hi_d;
  logic [HalfW-1:0]    dig_lo_q, dig_lo_d;
  logic                err_q, err_d;

  logic                req_hs, rsp_hs, start_comp;
  word_t               w0, w1, w9, w14, w_new, t1, t2;
  hash_t               sum;
  logic [HalfW-1:0]    bit_len;

  assign req_i.ready       = (state_q == S_IDLE);
  assign req_hs            = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.digest_high = dig_hi_q;
  assign rsp_o.digest_low  = dig_lo_q;
  assign rsp_o.length_error = err_q;
  assign rsp_hs            = out_valid_q && rsp_o.ready;

  assign w0    = blk_q[BlkBits-1 -: WordW];
  assign w1    = blk_q[BlkBits-1-WordW -: WordW];
  assign w9    = blk_q[BlkBits-1-9*WordW -: WordW];
  assign w14   = blk_q[BlkBits-1-14*WordW -: WordW];
  assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

  assign t1 = work_q[7] + big_sigma1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + RoundK[round_q] + w0;
  assign t2 = big_sigma0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_q[i] + work_q[i];
    end
  end

  assign bit_len = {count_q[CountW-2:0], 3'b000};

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    final_d     = final_q;
    round_d     = round_q;
    fill_d      = fill_q;
    count_d     = count_q;
    chain_d     = chain_q;
    work_d      = work_q;
    blk_d       = blk_q;
    out_valid_d = out_valid_q && !rsp_hs;
    dig_hi_d    = dig_hi_q;
    dig_lo_d    = dig_lo_q;
    err_d       = err_q;
    start_comp  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_hs) begin
          if (req_i.has_byte) begin
            blk_d  = {blk_q[BlkBits-ByteW-1:0], req_i.data_byte};
            fill_d = fill_q + 1'b1;
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
            if (fill_q == FillLast) begin
              start_comp = 1'b1;
              ret_d      = req_i.last_byte ? S_MARK : S_IDLE;
            end else if (req_i.last_byte) begin
              state_d = S_MARK;
            end
          end else if (req_i.last_byte) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        blk_d  = {blk_q[BlkBits-ByteW-1:0], PadMark};
        fill_d = fill_q + 1'b1;
        if (fill_q == FillLast) begin
          start_comp = 1'b1;
          ret_d      = S_ZERO;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (fill_q == FillLen) begin
          blk_d      = {blk_q[BlkBits-HalfW-1:0], bit_len};
          fill_d     = '0;
          start_comp = 1'b1;
          final_d    = 1'b1;
        end else begin
          blk_d  = {blk_q[BlkBits-ByteW-1:0], {ByteW{1'b0}}};
          fill_d = fill_q + 1'b1;
          if (fill_q == FillLast) begin
            start_comp = 1'b1;
            ret_d      = S_ZERO;
          end
        end
      end
      S_COMP: begin
        blk_d    = {blk_q[BlkBits-WordW-1:0], w_new};
        work_d   = {work_q[6:4], work_q[3] + t1, work_q[2:0], t1 + t2};
        round_d  = round_q + 1'b1;
        if (round_q == RoundLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!final_q) begin
          chain_d = sum;
          state_d = ret_q;
        end else if (!out_valid_q || rsp_o.ready) begin
          err_d       = count_q[CountW-1];
          dig_hi_d    = count_q[CountW-1] ? '0 : {sum[0], sum[1]};
          dig_lo_d    = count_q[CountW-1] ? '0 : {sum[2], sum[3]};
          out_valid_d = 1'b1;
          chain_d     = InitHash;
          count_d     = '0;
          fill_d      = '0;
          final_d     = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start_comp) begin
      state_d = S_COMP;
      round_d = '0;
      work_d  = chain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      final_q     <= 1'b0;
      round_q     <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      chain_q     <= InitHash;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      final_q     <= final_d;
      round_q     <= round_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    blk_q    <= blk_d;
    dig_hi_q <= dig_hi_d;
    dig_lo_q <= dig_lo_d;
    err_q    <= err_d;
  end

  a_fin_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && $past(state_q) != S_FIN) |->
      ($past(state_q) == S_COMP && $past(round_q) == RoundLast))
    else $error("chaining update without a full set of rounds");

  a_clean_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (fill_q == '0 && count_q == '0 && state_q == S_IDLE))
    else $error("message state not cleared with the result");

  a_no_req_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP || state_q == S_FIN) |-> !req_i.ready)
    else $error("request taken during compression");

endmodule

// ===== sim/tb_sha256_truncated_128_hasher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the SHA-256/128 byte-stream hasher
// Feeds message bytes over the request channel, with random gaps and
// back-pressure. A behavioral SHA-256 in the bench predicts each truncated
// digest unless a directed row fixes it; results are checked oldest first.
// ----------------------------------------------------------------------------
module tb_sha256_truncated_128_hasher;

  import sht128_pkg::ByteW;
  import sht128_pkg::HalfW;

  typedef struct packed {
    logic [HalfW-1:0] high;
    logic [HalfW-1:0] low;
    logic             err;
  } digest_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has_byte;
    logic             last_byte;
    logic             fixed;
    logic [HalfW-1:0] fixed_high;
    logic [HalfW-1:0] fixed_low;
  } stim_row_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [61:0] BYTE_TOTAL_MAX = {62{1'b1}};
  localparam logic [61:0] BYTE_TOTAL_LIMIT = {1'b0, {61{1'b1}}};
  localparam int unsigned GAP_MAX = 18;
  localparam int unsigned RANDOM_REQUESTS = 500;
  localparam int unsigned MIN_MESSAGES = 40;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned REPORT_MAX = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #2 clk_i = ~clk_i;

  sht128_in_if  req_if ();
  sht128_out_if rsp_if ();

  sha256_truncated_128_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [31:0]  chain_h [8];
  logic [31:0]  blk_words [16];
  int unsigned  blk_fill;
  logic [61:0]  byte_total;

  digest_t      pending_digests [$];
  int unsigned  fault_count;
  int unsigned  report_count;
  int unsigned  random_requests;
  bit           tx_burst;
  bit           rx_burst;

  stim_row_t directed_rows [14] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'hA5, 1'b0, 1'b1, 1'b1, 64'hE3B0C44298FC1C14, 64'h9AFBF4C8996FB924},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 64'hBA7816BF8F01CFEA, 64'h414140DE5DAE2223},
    '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h3C, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h5A, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0}
  };

  int unsigned corner_lengths [13] = '{0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 128};

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    logic [63:0] dbl;
    dbl = {v, v} >> n;
    return dbl[31:0];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    blk_fill = 0;
    byte_total = '0;
  endfunction

  function automatic void place_byte(input int unsigned pos, input logic [7:0] b);
    if (pos % 4 == 0) begin
      blk_words[pos / 4] = {b, 24'h0};
    end else begin
      blk_words[pos / 4][8 * (3 - pos % 4) +: 8] = b;
    end
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] s [8];
    logic [31:0] wt, t1, t2, x, y;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 0; i < 8; i++) s[i] = chain_h[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        x = w[(r + 1) % 16];
        y = w[(r + 14) % 16];
        wt = w[r % 16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[(r + 9) % 16]
           + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        w[r % 16] = wt;
      end
      t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + SHA_K[r] + wt;
      t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6];
      s[6] = s[5];
      s[5] = s[4];
      s[4] = s[3] + t1;
      s[3] = s[2];
      s[2] = s[1];
      s[1] = s[0];
      s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + s[i];
  endfunction

  // Absorb one request; returns 1 with the digest when the message ends.
  function automatic bit absorb_request(input logic [7:0] b, input bit has, input bit last,
                                        output digest_t d);
    logic [63:0] bit_len;
    bit          over;
    d = '0;
    if (has) begin
      place_byte(blk_fill, b);
      if (byte_total < BYTE_TOTAL_MAX) byte_total = byte_total + 1'b1;
      if (blk_fill == 63) begin
        compress_block();
        blk_fill = 0;
      end else begin
        blk_fill++;
      end
    end
    if (!last) return 1'b0;
    over = byte_total > BYTE_TOTAL_LIMIT;
    place_byte(blk_fill, 8'h80);
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        place_byte(blk_fill, 8'h00);
        blk_fill++;
      end
      compress_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      place_byte(blk_fill, 8'h00);
      blk_fill++;
    end
    bit_len = {byte_total, 2'b00} << 1;
    blk_words[14] = bit_len[63:32];
    blk_words[15] = bit_len[31:0];
    compress_block();
    if (over) begin
      d.err = 1'b1;
    end else begin
      d.high = {chain_h[0], chain_h[1]};
      d.low = {chain_h[2], chain_h[3]};
    end
    restart_hash();
    return 1'b1;
  endfunction

  task automatic send_request(input stim_row_t row);
    int unsigned gap;
    digest_t     d;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data_byte <= row.data;
    req_if.has_byte <= row.has_byte;
    req_if.last_byte <= row.last_byte;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (row.has_byte || row.last_byte) random_requests++;
    if (absorb_request(row.data, row.has_byte, row.last_byte, d)) begin
      if (row.fixed) begin
        d.high = row.fixed_high;
        d.low = row.fixed_low;
        d.err = 1'b0;
      end
      pending_digests.push_back(d);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_digests.size() != 0);
  endtask

  task automatic send_message(input int unsigned len);
    stim_row_t row;
    bit        end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        row = '0;
        row.data = 8'($urandom_range(0, 255));
        send_request(row);
      end
      row = '0;
      row.data = 8'($urandom_range(0, 255));
      row.has_byte = 1'b1;
      row.last_byte = end_on_byte && (i == len - 1);
      send_request(row);
    end
    if (!end_on_byte) begin
      row = '0;
      row.data = 8'($urandom_range(0, 255));
      row.last_byte = 1'b1;
      send_request(row);
    end
  endtask

  initial begin
    int unsigned stall;
    digest_t     want;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      if (pending_digests.size() == 0) begin
        fault_count++;
        if (report_count < REPORT_MAX) begin
          report_count++;
          $display("unexpected digest: high=%h low=%h err=%b", rsp_if.digest_high,
                   rsp_if.digest_low, rsp_if.length_error);
        end
      end else begin
        want = pending_digests.pop_front();
        if (rsp_if.digest_high !== want.high || rsp_if.digest_low !== want.low ||
            rsp_if.length_error !== want.err) begin
          fault_count++;
          if (report_count < REPORT_MAX) begin
            report_count++;
            $display("digest mismatch: expected high=%h low=%h err=%b", want.high,
                     want.low, want.err);
            $display("                 actual   high=%h low=%h err=%b", rsp_if.digest_high,
                     rsp_if.digest_low, rsp_if.length_error);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned messages;
    rst_ni = 1'b0;
    req_if.valid <= 1'b0;
    req_if.data_byte <= '0;
    req_if.has_byte <= 1'b0;
    req_if.last_byte <= 1'b0;
    fault_count = 0;
    report_count = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    restart_hash();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_results();

    random_requests = 0;
    messages = 0;
    while (random_requests < RANDOM_REQUESTS || messages < MIN_MESSAGES) begin
      case ($urandom_range(0, 3))
        0: len = corner_lengths[$urandom_range(0, 12)];
        1: len = $urandom_range(0, 70);
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len);
      messages++;
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && pending_digests.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sha256_truncated_128_hasher.f =====
rtl/sht128_pkg.sv
rtl/sht128_in_if.sv
rtl/sht128_out_if.sv
rtl/sha256_truncated_128_hasher.sv
sim/tb_sha256_truncated_128_hasher.sv
